[rtl/rbsi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types, constants and helpers for the 2D ray/box slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int NUM_W     = DIFF_W + FRAC_BITS;
    localparam int HI_W      = NUM_W - DATA_W;
    localparam int NUM_CELLS = DATA_W;
    localparam int NUM_LANES = 4;
    localparam int ADDR_W    = 4;

    localparam logic [DATA_W-1:0] T_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] T_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_MIN_X = 2'd0,
        REG_MIN_Y = 2'd1,
        REG_MAX_X = 2'd2,
        REG_MAX_Y = 2'd3
    } rbsi_reg_t;

    // lane 0: x min edge, 1: x max edge, 2: y min edge, 3: y max edge
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] dvs;
        logic              neg;
        logic              ovf;
    } rbsi_lane_t;

    typedef struct packed {
        rbsi_lane_t [NUM_LANES-1:0] lane;
        logic [1:0]                 dzero;
        logic [1:0]                 in_slab;
    } rbsi_div_t;

    function automatic rbsi_lane_t rbsi_lane_init(
        input logic [DATA_W-1:0] edge_v,
        input logic [DATA_W-1:0] org,
        input logic [DATA_W-1:0] dmag,
        input logic              dneg
    );
        rbsi_lane_t        l;
        logic [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0] mag;
        logic [NUM_W-1:0]  num;
        logic [HI_W-1:0]   hi;
        diff   = {edge_v[DATA_W-1], edge_v} - {org[DATA_W-1], org};
        mag    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        num    = {mag, {FRAC_BITS{1'b0}}};
        hi     = num[NUM_W-1:DATA_W];
        l.rem  = DATA_W'(hi);
        l.word = num[DATA_W-1:0];
        l.dvs  = dmag;
        l.neg  = diff[DIFF_W-1] ^ dneg;
        l.ovf  = (DATA_W'(hi) >= dmag);
        return l;
    endfunction

    function automatic logic [DATA_W-1:0] rbsi_sat(
        input logic [DATA_W-1:0] q,
        input logic              neg,
        input logic              ovf
    );
        logic [DATA_W-1:0] r;
        if (neg)
        begin
            r = (ovf || (q > T_MIN)) ? T_MIN : (~q + DATA_W'(1));
        end
        else
        begin
            r = (ovf || q[DATA_W-1]) ? T_MAX : q;
        end
        return r;
    endfunction

    function automatic logic rbsi_lt(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        return $signed(a) < $signed(b);
    endfunction

endpackage
`default_nettype wire

[rtl/rbsi_ray_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_ray_if
// Ray channel: origin and direction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbsi_ray_if;
    logic        valid;
    logic        ready;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] dir_x;
    logic [31:0] dir_y;

    modport source (output valid, origin_x, origin_y, dir_x, dir_y, input ready);
    modport sink   (input valid, origin_x, origin_y, dir_x, dir_y, output ready);
endinterface
`default_nettype wire

[rtl/rbsi_res_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_res_if
// Result channel: hit flag and entry parameter with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbsi_res_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] t_entry;

    modport source (output valid, hit, t_entry, input ready);
    modport sink   (input valid, hit, t_entry, output ready);
endinterface
`default_nettype wire

[rtl/ray_box_slab_intersect_2d.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_2d
// Slab test of a 2D ray against a configurable axis-aligned box.
// ----------------------------------------------------------------------------
// Pipeline: 35 register stages (1 prep loaded at the transaction edge,
//   32 divider cells, 2 final stages).
// Throughput: one ray per cycle; each stage holds its item under backpressure.
// Reset: asynchronous, active low; clears valids and box registers to zero.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_2d (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    rbsi_ray_if.sink                        ray,
    rbsi_res_if.source                      res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rbsi_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import rbsi_pkg::*;

    logic [DATA_W-1:0] box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;
    rbsi_reg_t         sel;

    rbsi_div_t cd [NUM_CELLS+1];
    logic      cv [NUM_CELLS+1];
    logic      cr [NUM_CELLS+1];

    assign pready = 1'b1;
    assign sel    = rbsi_reg_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        case (sel)
            REG_MIN_X: prdata = box_min_x_reg;
            REG_MIN_Y: prdata = box_min_y_reg;
            REG_MAX_X: prdata = box_max_x_reg;
            REG_MAX_Y: prdata = box_max_y_reg;
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_x_reg <= '0;
            box_min_y_reg <= '0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (sel)
                REG_MIN_X: box_min_x_reg <= pwdata;
                REG_MIN_Y: box_min_y_reg <= pwdata;
                REG_MAX_X: box_max_x_reg <= pwdata;
                REG_MAX_Y: box_max_y_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    rbsi_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray       (ray),
        .box_min_x (box_min_x_reg),
        .box_min_y (box_min_y_reg),
        .box_max_x (box_max_x_reg),
        .box_max_y (box_max_y_reg),
        .out_data  (cd[0]),
        .out_valid (cv[0]),
        .out_ready (cr[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        rbsi_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_data   (cd[g]),
            .in_valid  (cv[g]),
            .in_ready  (cr[g]),
            .out_data  (cd[g+1]),
            .out_valid (cv[g+1]),
            .out_ready (cr[g+1])
        );
    end

    rbsi_final u_final (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (cd[NUM_CELLS]),
        .in_valid (cv[NUM_CELLS]),
        .in_ready (cr[NUM_CELLS]),
        .res      (res)
    );

`ifndef NO_ASSERTIONS
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        ray.valid && ray.ready |=> cv[0])
        else $error("accepted ray not captured");
    a_chain_out: assert property (@(posedge clk) disable iff (!rst_n)
        cv[NUM_CELLS] && !cr[NUM_CELLS] |=> cv[NUM_CELLS] && $stable(cd[NUM_CELLS]))
        else $error("chain handoff fault");
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && sel == REG_MIN_X |=> box_min_x_reg == $past(pwdata))
        else $error("box_min_x write lost");
`endif
endmodule
`default_nettype wire

[rtl/rbsi_prep.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_prep
// Form edge-minus-origin magnitudes, divisor magnitudes, signs and overflow, plus zero-direction and in-slab flags.
// ----------------------------------------------------------------------------
module rbsi_prep (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    rbsi_ray_if.sink                        ray,
    input  wire logic [rbsi_pkg::DATA_W-1:0] box_min_x,
    input  wire logic [rbsi_pkg::DATA_W-1:0] box_min_y,
    input  wire logic [rbsi_pkg::DATA_W-1:0] box_max_x,
    input  wire logic [rbsi_pkg::DATA_W-1:0] box_max_y,
    output rbsi_pkg::rbsi_div_t             out_data,
    output logic                            out_valid,
    input  wire logic                       out_ready
);
    import rbsi_pkg::*;

    logic              valid_reg;
    rbsi_div_t         data_reg;
    rbsi_div_t         data_next;
    logic [DATA_W-1:0] dmag_x;
    logic [DATA_W-1:0] dmag_y;

    assign ray.ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        dmag_x = ray.dir_x[DATA_W-1] ? (~ray.dir_x + DATA_W'(1)) : ray.dir_x;
        dmag_y = ray.dir_y[DATA_W-1] ? (~ray.dir_y + DATA_W'(1)) : ray.dir_y;
        data_next.lane[0] = rbsi_lane_init(box_min_x, ray.origin_x, dmag_x,
                                           ray.dir_x[DATA_W-1]);
        data_next.lane[1] = rbsi_lane_init(box_max_x, ray.origin_x, dmag_x,
                                           ray.dir_x[DATA_W-1]);
        data_next.lane[2] = rbsi_lane_init(box_min_y, ray.origin_y, dmag_y,
                                           ray.dir_y[DATA_W-1]);
        data_next.lane[3] = rbsi_lane_init(box_max_y, ray.origin_y, dmag_y,
                                           ray.dir_y[DATA_W-1]);
        data_next.dzero[0]   = (ray.dir_x == '0);
        data_next.dzero[1]   = (ray.dir_y == '0);
        data_next.in_slab[0] = !rbsi_lt(ray.origin_x, box_min_x)
                               && !rbsi_lt(box_max_x, ray.origin_x);
        data_next.in_slab[1] = !rbsi_lt(ray.origin_y, box_min_y)
                               && !rbsi_lt(box_max_y, ray.origin_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ray.ready)
        begin
            valid_reg <= ray.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ray.valid && ray.ready)
        begin
            data_reg <= data_next;
        end
    end
endmodule
`default_nettype wire

[rtl/rbsi_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_cell
// One restoring-division step: one quotient bit for each of the four lanes.
// ----------------------------------------------------------------------------
module rbsi_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  rbsi_pkg::rbsi_div_t in_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    output rbsi_pkg::rbsi_div_t out_data,
    output logic               out_valid,
    input  wire logic          out_ready
);
    import rbsi_pkg::*;

    logic        valid_reg;
    rbsi_div_t   data_reg;
    rbsi_div_t   data_next;
    logic [DATA_W:0] rem2 [NUM_LANES];
    logic            ge   [NUM_LANES];
    logic [DATA_W:0] diff [NUM_LANES];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            rem2[i] = {in_data.lane[i].rem, in_data.lane[i].word[DATA_W-1]};
            diff[i] = rem2[i] - {1'b0, in_data.lane[i].dvs};
            ge[i]   = !diff[i][DATA_W] || rem2[i][DATA_W];
            data_next.lane[i].rem  = ge[i] ? diff[i][DATA_W-1:0] : rem2[i][DATA_W-1:0];
            data_next.lane[i].word = {in_data.lane[i].word[DATA_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end
endmodule
`default_nettype wire

[rtl/rbsi_final.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_final
// Saturate quotients, form per-axis ranges, then entry/exit and hit.
// ----------------------------------------------------------------------------
module rbsi_final (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  rbsi_pkg::rbsi_div_t in_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    rbsi_res_if.source         res
);
    import rbsi_pkg::*;

    logic              a_valid_reg;
    logic [DATA_W-1:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] xlo_next, xhi_next, ylo_next, yhi_next;
    logic              ok_next;
    logic [DATA_W-1:0] t [NUM_LANES];
    logic              a_ready;

    logic              b_valid_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] t_entry_reg;
    logic              hit_next;
    logic [DATA_W-1:0] tmin, tmax;

    assign a_ready  = !b_valid_reg || res.ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            t[i] = rbsi_sat(in_data.lane[i].word, in_data.lane[i].neg, in_data.lane[i].ovf);
        end
        if (in_data.dzero[0])
        begin
            xlo_next = T_MIN;
            xhi_next = T_MAX;
        end
        else
        begin
            xlo_next = rbsi_lt(t[0], t[1]) ? t[0] : t[1];
            xhi_next = rbsi_lt(t[0], t[1]) ? t[1] : t[0];
        end
        if (in_data.dzero[1])
        begin
            ylo_next = T_MIN;
            yhi_next = T_MAX;
        end
        else
        begin
            ylo_next = rbsi_lt(t[2], t[3]) ? t[2] : t[3];
            yhi_next = rbsi_lt(t[2], t[3]) ? t[3] : t[2];
        end
        ok_next = (!in_data.dzero[0] || in_data.in_slab[0])
                  && (!in_data.dzero[1] || in_data.in_slab[1]);
    end

    always_comb
    begin
        tmin     = rbsi_lt(ylo_reg, xlo_reg) ? xlo_reg : ylo_reg;
        tmax     = rbsi_lt(xhi_reg, yhi_reg) ? xhi_reg : yhi_reg;
        hit_next = ok_reg && !tmax[DATA_W-1] && !rbsi_lt(tmax, tmin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            xlo_reg <= xlo_next;
            xhi_reg <= xhi_next;
            ylo_reg <= ylo_next;
            yhi_reg <= yhi_next;
            ok_reg  <= ok_next;
        end
        if (a_valid_reg && a_ready)
        begin
            hit_reg     <= hit_next;
            t_entry_reg <= hit_next ? tmin : '0;
        end
    end

    assign res.valid   = b_valid_reg;
    assign res.hit     = hit_reg;
    assign res.t_entry = t_entry_reg;

`ifndef NO_ASSERTIONS
    a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.hit |-> res.t_entry == '0)
        else $error("t_entry nonzero on miss");
    a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !res.ready |=> b_valid_reg && $stable(t_entry_reg))
        else $error("result dropped while stalled");
    a_a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_ready |=> b_valid_reg)
        else $error("stage A item lost");
`endif
endmodule
`default_nettype wire

[tb/ray_box_slab_intersect_2d_tb.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_2d_tb
// Streams rays through the slab-test block under random source gaps and sink
// stalls, predicts hit and entry parameter per ray, and checks each result in
// order. The box registers are rewritten over APB between phases.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_2d_tb;
    import rbsi_pkg::*;

    typedef struct {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] dx;
        logic [31:0] dy;
    } ray_t;

    typedef struct {
        logic        hit;
        logic [31:0] t_entry;
    } hit_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    rbsi_ray_if ray ();
    rbsi_res_if res ();

    ray_box_slab_intersect_2d u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .ray     (ray.sink),
        .res     (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    longint box_lo_x, box_lo_y, box_hi_x, box_hi_y;
    ray_t   ray_q[$];
    hit_t   hit_q[$];
    int     errors;
    int     gap_cnt;
    int     stall_cnt;
    bit     hold_src;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("[ray_box_slab_intersect_2d] ERROR");
        $finish;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit axis_span(longint lo, longint hi, longint o, longint d,
                                     output longint tlo, output longint thi);
        longint a;
        longint b;
        if (d == 0)
        begin
            tlo = -64'sd2147483648;
            thi = 64'sd2147483647;
            return (o >= lo) && (o <= hi);
        end
        a = clamp32(((lo - o) * 65536) / d);
        b = clamp32(((hi - o) * 65536) / d);
        tlo = (a < b) ? a : b;
        thi = (a < b) ? b : a;
        return 1'b1;
    endfunction

    function automatic hit_t trace_ray(ray_t r);
        hit_t   h;
        longint xl, xh, yl, yh, tn, tx;
        h.hit = 1'b0;
        h.t_entry = '0;
        if (axis_span(box_lo_x, box_hi_x, longint'($signed(r.ox)), longint'($signed(r.dx)),
                      xl, xh) &&
            axis_span(box_lo_y, box_hi_y, longint'($signed(r.oy)), longint'($signed(r.dy)),
                      yl, yh))
        begin
            tn = (xl > yl) ? xl : yl;
            tx = (xh < yh) ? xh : yh;
            if (tx >= 0 && tn <= tx)
            begin
                h.hit = 1'b1;
                h.t_entry = tn[31:0];
            end
        end
        return h;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray.valid <= 1'b0;
            ray.origin_x <= '0;
            ray.origin_y <= '0;
            ray.dir_x <= '0;
            ray.dir_y <= '0;
            gap_cnt <= 0;
        end
        else if (!ray.valid || ray.ready)
        begin
            if (ray.valid)
                hit_q.push_back(trace_ray('{ray.origin_x, ray.origin_y, ray.dir_x, ray.dir_y}));
            if (gap_cnt > 0)
            begin
                gap_cnt <= gap_cnt - 1;
                ray.valid <= 1'b0;
            end
            else if (ray_q.size() > 0 && !hold_src)
            begin
                ray_t r;
                r = ray_q.pop_front();
                ray.valid <= 1'b1;
                ray.origin_x <= r.ox;
                ray.origin_y <= r.oy;
                ray.dir_x <= r.dx;
                ray.dir_y <= r.dy;
                gap_cnt <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
            else
                ray.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (hit_q.size() == 0)
                begin
                    $display("unexpected result");
                    errors++;
                end
                else
                begin
                    hit_t e;
                    e = hit_q.pop_front();
                    if (res.hit !== e.hit)
                        report("hit", 32'(res.hit), 32'(e.hit));
                    if (res.t_entry !== e.t_entry)
                        report("t_entry", res.t_entry, e.t_entry);
                end
            end
            if (stall_cnt > 0)
            begin
                stall_cnt <= stall_cnt - 1;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
                if (res.valid && res.ready)
                    stall_cnt <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
    end

    task automatic write_box(rbsi_reg_t idx, logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_X: box_lo_x = longint'($signed(v));
            REG_MIN_Y: box_lo_y = longint'($signed(v));
            REG_MAX_X: box_hi_x = longint'($signed(v));
            default:   box_hi_y = longint'($signed(v));
        endcase
    endtask

    task automatic set_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                           logic [31:0] y1);
        write_box(REG_MIN_X, x0);
        write_box(REG_MIN_Y, y0);
        write_box(REG_MAX_X, x1);
        write_box(REG_MAX_Y, y1);
    endtask

    task automatic drain();
        while (ray_q.size() > 0 || ray.valid || hit_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord(logic [31:0] lo, logic [31:0] hi);
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return $urandom();
        if (k == 1)
            return lo;
        if (k == 2)
            return hi;
        if (k == 3)
            return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        return lo + (($urandom() % 65536) * ((hi - lo) >> 16 | 1));
    endfunction

    function automatic logic [31:0] pick_dir();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        if (k == 1)
            return $urandom();
        if (k == 2)
            return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hffff_ffff;
        if (k == 3)
            return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
    endfunction

    task automatic add_random(int n, logic [31:0] x0, logic [31:0] y0,
                              logic [31:0] x1, logic [31:0] y1);
        for (int i = 0; i < n; i++)
            ray_q.push_back('{pick_coord(x0 - 32'h20000, x1 + 32'h20000),
                              pick_coord(y0 - 32'h20000, y1 + 32'h20000),
                              pick_dir(), pick_dir()});
    endtask

    initial
    begin
        logic [31:0] x0, y0, x1, y1;
        errors = 0;
        hold_src = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        box_lo_x = 0;
        box_lo_y = 0;
        box_hi_x = 0;
        box_hi_y = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset box is a point at the origin
        ray_q.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
        ray_q.push_back('{32'h1, 32'h0, 32'h0, 32'h0});
        drain();

        set_box(32'hfffe_0000, 32'hffff_0000, 32'h0003_0000, 32'h0002_0000);
        ray_q.push_back('{32'hfffb_0000, 32'h0, 32'h0001_0000, 32'h0});
        ray_q.push_back('{32'hfffb_0000, 32'h0, 32'hffff_0000, 32'h0});
        ray_q.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
        ray_q.push_back('{32'h0, 32'h0005_0000, 32'h0, 32'h0});
        ray_q.push_back('{32'h0, 32'hffff_0000, 32'h0001_0000, 32'h0});
        ray_q.push_back('{32'h0, 32'h0002_0000, 32'h0, 32'hffff_0000});
        ray_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001});
        ray_q.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000});
        ray_q.push_back('{32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0});
        ray_q.push_back('{32'hfffb_0000, 32'hfffb_0000, 32'h0001_0000, 32'h0001_0000});
        ray_q.push_back('{32'hffff_ffff, 32'h5555_aaaa, 32'haaaa_5555, 32'hffff_ffff});
        drain();

        // reversed box
        set_box(32'h0003_0000, 32'h0002_0000, 32'hfffe_0000, 32'hffff_0000);
        ray_q.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
        ray_q.push_back('{32'hfffb_0000, 32'h0, 32'h0001_0000, 32'h0001_0000});
        drain();

        // full range box
        set_box(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        ray_q.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff});
        ray_q.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0});
        add_random(200, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            x0 = $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000;
            y0 = $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000;
            x1 = x0 + $urandom_range(0, 32'h8_0000);
            y1 = y0 + $urandom_range(0, 32'h8_0000);
            if (p == 5)
                x1 = x0 - 32'h1_0000;
            set_box(x0, y0, x1, y1);
            add_random(220, x0, y0, x1, y1);
            if (p == 2)
            begin
                hold_src = 1'b1;
                while (ray.valid || hit_q.size() > 0)
                    @(posedge clk);
                hold_src = 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("[ray_box_slab_intersect_2d] OK");
        else
            $display("[ray_box_slab_intersect_2d] ERROR");
        $finish;
    end
endmodule
